[rtl/assert_macros.svh]
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is low.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[rtl/bsfd_pkg.sv]
// ----------------------------------------------------------------------------
// bsfd_pkg
// Types and constants of the byte-stuffing frame decoder.
// ----------------------------------------------------------------------------
package bsfd_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned ERR_W  = 2;
    localparam int unsigned IDX_W  = 2;

    localparam logic [ERR_W-1:0] ERR_NONE       = 2'd0;
    localparam logic [ERR_W-1:0] ERR_TERMINATED = 2'd1;
    localparam logic [ERR_W-1:0] ERR_ILLEGAL    = 2'd2;

    localparam logic [IDX_W-1:0] CFG_FRAME_BOUND = 2'd0;
    localparam logic [IDX_W-1:0] CFG_ESCAPE      = 2'd1;
    localparam logic [IDX_W-1:0] CFG_ECHO_BOUND  = 2'd2;
    localparam logic [IDX_W-1:0] CFG_ECHO_ESCAPE = 2'd3;

    localparam logic [BYTE_W-1:0] RST_FRAME_BOUND = 8'd126;
    localparam logic [BYTE_W-1:0] RST_ESCAPE      = 8'd125;
    localparam logic [BYTE_W-1:0] RST_ECHO_BOUND  = 8'd94;
    localparam logic [BYTE_W-1:0] RST_ECHO_ESCAPE = 8'd93;

    typedef struct packed {
        logic              we;
        logic [IDX_W-1:0]  idx;
        logic [BYTE_W-1:0] wdata;
    } t_cfg_wr;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              data_valid;
        logic              frame_end;
        logic [ERR_W-1:0]  error_code;
    } t_result;

endpackage

[rtl/byte_stuffing_frame_decoder.sv]
// ----------------------------------------------------------------------------
// byte_stuffing_frame_decoder
// Deframes a byte-stuffed link stream: bounds, escapes and error drop.
//
//   channel   dir  payload
//   s_*       in   tdata[7:0] byte_in
//   m_*       out  tdata[7:0] data_byte, [8] data_valid; tlast frame_end;
//                  tuser[1:0] error_code
//   cfg_*     in   idx 0..3 selects a code register, wdata 8 bits
//
// One byte accepted per cycle while s_tready is high; its result is registered
// in the output register, or the skid stage if the output stalls. Decode and
// next-flag logic are combinational. s_tready drops only while the skid holds
// an item. Reset is synchronous and restores the default codes and flags.
// ----------------------------------------------------------------------------
module byte_stuffing_frame_decoder (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_idx,
    input  logic [7:0] i_cfg_wdata,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,   // [7:0] byte_in
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [15:0] o_m_tdata,  // [7:0] data_byte, [8] data_valid, rest zero
    output logic       o_m_tlast,
    output logic [1:0] o_m_tuser    // [1:0] error_code
);
    import bsfd_pkg::*;

    t_cfg_wr w_cfg;
    t_result w_res;
    t_result w_out;
    logic    w_res_valid;
    logic    w_accept;

    assign w_cfg.we    = i_cfg_we;
    assign w_cfg.idx   = i_cfg_idx;
    assign w_cfg.wdata = i_cfg_wdata;
    assign w_accept    = i_s_tvalid && o_s_tready;

    bsfd_decode u_decode (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_accept    (w_accept),
        .i_byte      (i_s_tdata),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    bsfd_out_buf u_out_buf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_accept && w_res_valid),
        .i_data      (w_res),
        .o_ready     (o_s_tready),
        .o_valid     (o_m_tvalid),
        .o_data      (w_out),
        .i_pop_ready (i_m_tready)
    );

    assign o_m_tdata = {7'd0, w_out.data_valid, w_out.data_byte};
    assign o_m_tlast = w_out.frame_end;
    assign o_m_tuser = w_out.error_code;

endmodule

[rtl/bsfd_decode.sv]
// ----------------------------------------------------------------------------
// bsfd_decode
// Code registers, escape and discard flags, and the per-byte decode.
// ----------------------------------------------------------------------------
module bsfd_decode (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  bsfd_pkg::t_cfg_wr       i_cfg,
    input  logic                    i_accept,
    input  logic [7:0]              i_byte,
    output logic                    o_res_valid,
    output bsfd_pkg::t_result       o_res
);
    import bsfd_pkg::*;

    logic [BYTE_W-1:0] r_frame_bound;
    logic [BYTE_W-1:0] r_escape;
    logic [BYTE_W-1:0] r_echo_bound;
    logic [BYTE_W-1:0] r_echo_escape;
    logic              r_escape_pending;
    logic              r_discarding;
    logic              n_escape_pending;
    logic              n_discarding;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_bound <= RST_FRAME_BOUND;
            r_escape      <= RST_ESCAPE;
            r_echo_bound  <= RST_ECHO_BOUND;
            r_echo_escape <= RST_ECHO_ESCAPE;
        end else if (i_cfg.we) begin
            unique case (i_cfg.idx)
                CFG_FRAME_BOUND: r_frame_bound <= i_cfg.wdata;
                CFG_ESCAPE:      r_escape      <= i_cfg.wdata;
                CFG_ECHO_BOUND:  r_echo_bound  <= i_cfg.wdata;
                CFG_ECHO_ESCAPE: r_echo_escape <= i_cfg.wdata;
                default:         r_frame_bound <= r_frame_bound;
            endcase
        end
    end

    always_comb begin
        n_escape_pending = r_escape_pending;
        n_discarding     = r_discarding;
        o_res_valid      = 1'b0;
        o_res            = '0;
        priority if (i_byte == r_frame_bound) begin
            o_res_valid      = 1'b1;
            o_res.frame_end  = 1'b1;
            o_res.error_code = r_escape_pending ? ERR_TERMINATED : ERR_NONE;
            n_escape_pending = 1'b0;
            n_discarding     = 1'b0;
        end else if (r_discarding) begin
            o_res_valid = 1'b0;
        end else if (r_escape_pending) begin
            n_escape_pending = 1'b0;
            o_res_valid      = 1'b1;
            priority if (i_byte == r_echo_bound) begin
                o_res.data_byte  = r_frame_bound;
                o_res.data_valid = 1'b1;
            end else if (i_byte == r_echo_escape) begin
                o_res.data_byte  = r_escape;
                o_res.data_valid = 1'b1;
            end else begin
                o_res.error_code = ERR_ILLEGAL;
                n_discarding     = 1'b1;
            end
        end else if (i_byte == r_escape) begin
            n_escape_pending = 1'b1;
        end else begin
            o_res_valid      = 1'b1;
            o_res.data_byte  = i_byte;
            o_res.data_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_escape_pending <= 1'b0;
            r_discarding     <= 1'b0;
        end else if (i_accept) begin
            r_escape_pending <= n_escape_pending;
            r_discarding     <= n_discarding;
        end
    end

endmodule

[rtl/bsfd_out_buf.sv]
// ----------------------------------------------------------------------------
// bsfd_out_buf
// Output register with a skid stage; decouples the input from output stalls.
// ----------------------------------------------------------------------------
module bsfd_out_buf (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  bsfd_pkg::t_result   i_data,
    output logic                o_ready,
    output logic                o_valid,
    output bsfd_pkg::t_result   o_data,
    input  logic                i_pop_ready
);
    import bsfd_pkg::*;

    logic    r_head_valid;
    logic    r_skid_valid;
    t_result r_head;
    t_result r_skid;
    logic    n_head_valid;
    logic    n_skid_valid;
    t_result n_head;
    t_result n_skid;

    always_comb begin
        n_head_valid = r_head_valid;
        n_skid_valid = r_skid_valid;
        n_head       = r_head;
        n_skid       = r_skid;
        if ((r_head_valid && i_pop_ready) || !r_head_valid) begin
            if (r_skid_valid) begin
                n_head       = r_skid;
                n_head_valid = 1'b1;
                n_skid_valid = 1'b0;
            end else begin
                n_head       = i_data;
                n_head_valid = i_push;
            end
        end else if (i_push) begin
            n_skid       = i_data;
            n_skid_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_head_valid <= n_head_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_head <= n_head;
        r_skid <= n_skid;
    end

    assign o_ready = !r_skid_valid;
    assign o_valid = r_head_valid;
    assign o_data  = r_head;

endmodule

[rtl/bsfd_checker.sv]
// ----------------------------------------------------------------------------
// bsfd_checker
// Port-level checks on the decoder's output stream.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bsfd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [15:0] o_m_tdata,
    input logic        o_m_tlast,
    input logic [1:0]  o_m_tuser
);
    import bsfd_pkg::*;

    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready,
        o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast) && $stable(o_m_tuser))
    `ASSERT_NOW(a_end_no_data, i_clk, i_rst_n, o_m_tvalid && o_m_tlast,
        o_m_tdata[8] == 1'b0 && o_m_tdata[7:0] == 8'd0 && o_m_tuser != ERR_ILLEGAL)
    `ASSERT_NOW(a_data_clean, i_clk, i_rst_n, o_m_tvalid && o_m_tdata[8],
        !o_m_tlast && o_m_tuser == ERR_NONE)
    `ASSERT_NOW(a_err_code, i_clk, i_rst_n, o_m_tvalid,
        o_m_tuser <= ERR_ILLEGAL && o_m_tdata[15:9] == 7'd0)
    `ASSERT_NOW(a_some_kind, i_clk, i_rst_n, o_m_tvalid,
        o_m_tdata[8] || o_m_tlast || o_m_tuser == ERR_ILLEGAL)

endmodule

bind byte_stuffing_frame_decoder bsfd_checker u_bsfd_checker (.*);
